@@ hdl/yuv420_to_rgb_stream_macros.svh @@
// Assertion macros shared by the conversion block.
`ifndef YUV420_TO_RGB_STREAM_MACROS_SVH
`define YUV420_TO_RGB_STREAM_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define YUVRGB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define YUVRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/yuvrgb_pkg.sv @@
package yuvrgb_pkg;

    // Configuration port
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 12;
    localparam int HALF_WIDTH_W  = 11;
    localparam int HALF_HEIGHT_W = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_HEIGHT = 1'b1;

    localparam logic [HALF_WIDTH_W-1:0]  HALF_WIDTH_RST  = 11'd320;
    localparam logic [HALF_HEIGHT_W-1:0] HALF_HEIGHT_RST = 12'd240;

    // Pixel and stream widths
    localparam int PIX_W    = 8;
    localparam int CHROMA_W = 2 * PIX_W;
    localparam int TDATA_W  = 3 * PIX_W;

    // Q16 conversion coefficients and accumulator width
    localparam int ACC_W = 27;
    localparam logic signed [17:0] K_RV = 18'sd91881;
    localparam logic signed [17:0] K_GU = 18'sd22544;
    localparam logic signed [17:0] K_GV = 18'sd46793;
    localparam logic signed [17:0] K_BU = 18'sd116130;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Per-pixel control from the raster counters
    typedef struct packed {
        logic take_chroma;   // even column: pick up new chroma
        logic from_input;    // even row: chroma comes from the stream
        logic frame_end;     // last pixel of the frame
    } pix_ctl_t;

    // Floor a Q16 sum and clamp it to 0..255
    function automatic logic [PIX_W-1:0] clamp_q16(input acc_t acc);
        logic [PIX_W-1:0] res;
        if (acc[ACC_W-1])
        begin
            res = '0;
        end
        else if (acc[ACC_W-2:16+PIX_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = acc[16+PIX_W-1:16];
        end
        return res;
    endfunction

endpackage

@@ hdl/yuvrgb_line_store.sv @@
module yuvrgb_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                           clk,
    input  logic                           wen,
    input  logic [AW-1:0]                  waddr,
    input  logic [yuvrgb_pkg::CHROMA_W-1:0] wdata,
    input  logic                           ren,
    input  logic [AW-1:0]                  raddr,
    output logic [yuvrgb_pkg::CHROMA_W-1:0] rdata
);
    import yuvrgb_pkg::*;

    logic [CHROMA_W-1:0] mem [DEPTH];
    logic [CHROMA_W-1:0] rdata_reg;

    // Store chroma of the even row
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read back for the odd row
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/yuvrgb_raster_ctr.sv @@
module yuvrgb_raster_ctr #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int SLOT_W     = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [yuvrgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              advance,
    output logic [SLOT_W-1:0]                 slot,
    output yuvrgb_pkg::pix_ctl_t              ctl
);
    import yuvrgb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = MAX_WIDTH / 2;
    localparam int LH = MAX_HEIGHT / 2;

    logic [HALF_WIDTH_W-1:0]  half_width_reg;
    logic [HALF_HEIGHT_W-1:0] half_height_reg;
    logic [CW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;
    logic [CW-1:0] hw_sat;
    logic [RW-1:0] hh_sat;
    logic [CW:0]   width;
    logic [RW:0]   height;
    logic          last_col, last_row;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= HALF_WIDTH_RST;
            half_height_reg <= HALF_HEIGHT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wdata[HALF_WIDTH_W-1:0];
                CFG_HALF_HEIGHT: half_height_reg <= cfg_wdata[HALF_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate dimensions to 1..max/2
    always_comb
    begin
        if (half_width_reg == '0)
            hw_sat = CW'(1);
        else if (32'(half_width_reg) > LW)
            hw_sat = CW'(LW);
        else
            hw_sat = CW'(half_width_reg);

        if (half_height_reg == '0)
            hh_sat = RW'(1);
        else if (32'(half_height_reg) > LH)
            hh_sat = RW'(LH);
        else
            hh_sat = RW'(half_height_reg);
    end

    assign width  = {hw_sat, 1'b0};
    assign height = {hh_sat, 1'b0};

    // Restart counters that sit beyond a shrunk frame
    assign col_eff  = ({1'b0, col_reg} >= width)  ? '0 : col_reg;
    assign row_eff  = ({1'b0, row_reg} >= height) ? '0 : row_reg;
    assign last_col = ({1'b0, col_eff} == width - (CW+1)'(1));
    assign last_row = ({1'b0, row_eff} == height - (RW+1)'(1));

    // Advance in raster order
    always_comb
    begin
        col_next = col_eff + CW'(1);
        row_next = row_eff;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_eff + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign slot            = col_eff[CW-1:1];
    assign ctl.take_chroma = ~col_eff[0];
    assign ctl.from_input  = ~row_eff[0];
    assign ctl.frame_end   = last_col & last_row;

endmodule

@@ hdl/yuvrgb_color.sv @@
module yuvrgb_color (
    input  logic [yuvrgb_pkg::PIX_W-1:0]    luma,
    input  logic [yuvrgb_pkg::CHROMA_W-1:0] chroma,
    output logic [yuvrgb_pkg::PIX_W-1:0]    red,
    output logic [yuvrgb_pkg::PIX_W-1:0]    green,
    output logic [yuvrgb_pkg::PIX_W-1:0]    blue
);
    import yuvrgb_pkg::*;

    logic signed [8:0] cb, cr;
    acc_t y_q16;
    acc_t prod_rv, prod_gu, prod_gv, prod_bu;
    acc_t acc_r, acc_g, acc_b;

    // Remove the chroma offset
    assign cb = signed'({1'b0, chroma[CHROMA_W-1:PIX_W]} - CHROMA_OFFSET);
    assign cr = signed'({1'b0, chroma[PIX_W-1:0]} - CHROMA_OFFSET);

    assign y_q16 = signed'({3'b000, luma, 16'h0000});

    // Q16 products
    assign prod_rv = ACC_W'(K_RV) * ACC_W'(cr);
    assign prod_gu = ACC_W'(K_GU) * ACC_W'(cb);
    assign prod_gv = ACC_W'(K_GV) * ACC_W'(cr);
    assign prod_bu = ACC_W'(K_BU) * ACC_W'(cb);

    assign acc_r = y_q16 + prod_rv;
    assign acc_g = y_q16 - prod_gu - prod_gv;
    assign acc_b = y_q16 + prod_bu;

    // Floor and clamp
    assign red   = clamp_q16(acc_r);
    assign green = clamp_q16(acc_g);
    assign blue  = clamp_q16(acc_b);

endmodule

@@ hdl/yuv420_to_rgb_stream.sv @@
// 4:2:0 YCbCr to RGB pixel stream converter (BT.601 full range).
// Slave stream: one request per pixel in raster order, tdata = {Cr, Cb, Y}.
// Cb/Cr are taken only at even row and even column; they are kept in an
// on-chip line store of MAX_WIDTH/2 entries for the odd row and held across
// the odd column (nearest-neighbour upsampling).
// Master stream: tdata = {B, G, R}, tlast marks the last pixel of a frame.
// Frame size is set through the write port as half width and half height
// (register 0 and 1); write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver does not stall. An
// accepted pixel loads the input stage and the line-store read register
// together; the output register then takes the converted pixel, which is
// presented on the master side.
// Reset clears counters and held chroma and loads 320 x 240 halves. The line
// store is not cleared: each frame starts on an even row, which fills it.
// When the receiver stalls, the output register holds its pixel and an empty
// input stage still takes one more pixel before s_tready drops.
module yuv420_to_rgb_stream #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [yuvrgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [yuvrgb_pkg::TDATA_W-1:0]    s_tdata,   // luma, chroma_blue, chroma_red
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [yuvrgb_pkg::TDATA_W-1:0]    m_tdata,   // red, green, blue
    output logic                              m_tlast    // frame_end
);
    import yuvrgb_pkg::*;

    `include "yuv420_to_rgb_stream_macros.svh"

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int LINE_AW = CW - 1;
    localparam int LINE_D  = MAX_WIDTH / 2;

    logic                s_accept, out_adv, s1_adv;
    logic [LINE_AW-1:0]  slot;
    pix_ctl_t            ctl;
    logic                line_wen;
    logic [CHROMA_W-1:0] line_rdata;

    logic                s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]    s1_luma_reg;
    logic [CHROMA_W-1:0] s1_chroma_reg;
    pix_ctl_t            s1_ctl_reg;
    logic [CHROMA_W-1:0] held_reg, held_next;
    logic [CHROMA_W-1:0] chroma_cur;
    logic [PIX_W-1:0]    red, green, blue;

    logic                out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]  out_data_reg;
    logic                out_last_reg;

    // Handshake
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_adv;
    assign s_accept = s_tvalid && s_tready;
    assign s1_adv   = s1_valid_reg && out_adv;

    yuvrgb_raster_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SLOT_W     (LINE_AW)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (s_accept),
        .slot      (slot),
        .ctl       (ctl)
    );

    // Write chroma at even row and even column, read it back on every request
    assign line_wen = s_accept && ctl.take_chroma && ctl.from_input;

    yuvrgb_line_store #(
        .DEPTH (LINE_D),
        .AW    (LINE_AW)
    ) u_line (
        .clk   (clk),
        .wen   (line_wen),
        .waddr (slot),
        .wdata ({s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]}),
        .ren   (s_accept),
        .raddr (slot),
        .rdata (line_rdata)
    );

    // Input stage
    assign s1_valid_next = s_accept ? 1'b1 : (out_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_luma_reg   <= s_tdata[PIX_W-1:0];
            s1_chroma_reg <= {s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]};
            s1_ctl_reg    <= ctl;
        end
    end

    // Select chroma: new sample, line store, or held value
    always_comb
    begin
        if (s1_ctl_reg.take_chroma)
            chroma_cur = s1_ctl_reg.from_input ? s1_chroma_reg : line_rdata;
        else
            chroma_cur = held_reg;
    end

    assign held_next = s1_adv ? chroma_cur : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    yuvrgb_color u_color (
        .luma   (s1_luma_reg),
        .chroma (chroma_cur),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    // Output register
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {blue, green, red};
            out_last_reg <= s1_ctl_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `YUVRGB_ASSERT(a_ready_when_out_free, !out_valid_reg |-> s_tready,
        "input not ready while output register is free")
    `YUVRGB_ASSERT_NEXT(a_accept_fills_stage, s_accept, s1_valid_reg,
        "accepted request did not reach the input stage")
    `YUVRGB_ASSERT_NEXT(a_stage_moves_out, s1_adv, m_tvalid,
        "converted pixel did not reach the output register")
    `YUVRGB_ASSERT_NEXT(a_stalled_stage_holds, s1_valid_reg && !out_adv,
        s1_valid_reg && $stable(s1_luma_reg) && $stable(s1_ctl_reg),
        "stalled input stage lost or changed its pixel")

endmodule
